// ----- design/urc_pkg.sv -----
package urc_pkg;

    localparam int RING_DEPTH_DEF  = 5;
    localparam int STAMP_WIDTH_DEF = 32;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [15:0] DIST_MAX = 16'hFFFF;

    localparam logic        MODE_RESET = 1'b0;
    localparam logic [4:0]  RATE_RESET = 5'd16;
    localparam logic [19:0] TPM_RESET  = 20'd400000;
    localparam logic [15:0] TPC_RESET  = 16'd23200;

    localparam logic [15:0] CMD_STOP  = 16'd0;
    localparam logic [15:0] CMD_START = 16'd1;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_EMPTY_STOPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY_WAIT    = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ECHO = 2'd1,
        OP_READ = 2'd2,
        OP_CMD  = 2'd3
    } urc_op_t;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_RATE = 2'd1,
        REG_TPM  = 2'd2,
        REG_TPC  = 2'd3
    } urc_reg_t;

    typedef struct packed {
        logic        mode;
        logic [4:0]  rate;
        logic [19:0] tpm;
        logic [15:0] tpc;
    } urc_cfg_t;

    typedef struct packed {
        logic exec;
        logic div_start;
        logic push;
        logic load_out;
    } urc_cmd_t;

    typedef struct packed {
        logic fall_pending;
        logic div_done;
    } urc_stat_t;

    // Trigger period in milliseconds, 1000 / rate with the rate clamped to 1..16.
    function automatic logic [9:0] period_ms(input logic [4:0] rate);
        logic [9:0] p;
        case (rate)
            5'd0:    p = 10'd1000;
            5'd1:    p = 10'd1000;
            5'd2:    p = 10'd500;
            5'd3:    p = 10'd333;
            5'd4:    p = 10'd250;
            5'd5:    p = 10'd200;
            5'd6:    p = 10'd166;
            5'd7:    p = 10'd142;
            5'd8:    p = 10'd125;
            5'd9:    p = 10'd111;
            5'd10:   p = 10'd100;
            5'd11:   p = 10'd90;
            5'd12:   p = 10'd83;
            5'd13:   p = 10'd76;
            5'd14:   p = 10'd71;
            5'd15:   p = 10'd66;
            default: p = 10'd62;
        endcase
        return p;
    endfunction

endpackage

// ----- design/urc_div.sv -----
module urc_div #(
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [15:0]   divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic [15:0]   rem_reg, rem_next;
    logic [15:0]   dvs_reg;
    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;
    logic          ge;

    // Restoring division: the dividend shifts out of dq_reg while quotient bits shift in.
    assign rem_sh  = {rem_reg, dq_reg[DW-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = dq_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dq_next   = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - CW'(1);
                dq_next  = {dq_reg[DW-2:0], ge};
                rem_next = ge ? rem_sub[15:0] : rem_sh[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

endmodule

// ----- design/urc_regs.sv -----
module urc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [urc_pkg::ADDR_W-1:0] paddr,
    input  logic [urc_pkg::DATA_W-1:0] pwdata,
    output logic [urc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output urc_pkg::urc_cfg_t          cfg,
    output logic                       mode_wr
);
    import urc_pkg::*;

    logic        mode_reg;
    logic [4:0]  rate_reg;
    logic [19:0] tpm_reg;
    logic [15:0] tpc_reg;
    logic        wr_en;
    urc_reg_t    idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign idx     = urc_reg_t'(paddr[3:2]);
    assign mode_wr = wr_en && (idx == REG_MODE);

    assign cfg.mode = mode_reg;
    assign cfg.rate = rate_reg;
    assign cfg.tpm  = tpm_reg;
    assign cfg.tpc  = tpc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            rate_reg <= RATE_RESET;
            tpm_reg  <= TPM_RESET;
            tpc_reg  <= TPC_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_MODE: mode_reg <= pwdata[0];
                REG_RATE: rate_reg <= pwdata[4:0];
                REG_TPM:  tpm_reg  <= pwdata[19:0];
                REG_TPC:  tpc_reg  <= pwdata[15:0];
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MODE: prdata = {31'd0, mode_reg};
            REG_RATE: prdata = {27'd0, rate_reg};
            REG_TPM:  prdata = {12'd0, tpm_reg};
            REG_TPC:  prdata = {16'd0, tpc_reg};
            default:  prdata = '0;
        endcase
    end

endmodule

// ----- design/urc_datapath.sv -----
module urc_datapath #(
    parameter int RING_DEPTH  = urc_pkg::RING_DEPTH_DEF,
    parameter int STAMP_WIDTH = urc_pkg::STAMP_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  urc_pkg::urc_cmd_t cmd,
    output urc_pkg::urc_stat_t stat,
    input  urc_pkg::urc_cfg_t cfg,
    input  logic              mode_wr,
    input  urc_pkg::urc_op_t  op,
    input  logic [15:0]       command_value,
    output logic              fire_trigger,
    output logic              read_valid,
    output logic [15:0]       distance_cm,
    output logic [1:0]        read_status
);
    import urc_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    logic [STAMP_WIDTH-1:0] ts_reg;
    logic [STAMP_WIDTH-1:0] rise_reg;
    logic                   phase_reg;
    logic                   running_reg;
    logic [19:0]            pre_reg;
    logic [9:0]             elapsed_reg;
    logic [IDX_W-1:0]       wr_reg;
    logic [IDX_W-1:0]       rd_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [15:0]            ring [RING_DEPTH];

    logic                   fire_reg;
    logic                   valid_reg;
    logic [15:0]            dist_reg;
    logic [1:0]             status_reg;

    logic [19:0]            tpm_eff;
    logic [15:0]            tpc_eff;
    logic [9:0]             period;
    logic [19:0]            pre_inc;
    logic [9:0]             el_inc;
    logic                   ms_hit;
    logic                   period_hit;
    logic                   ring_empty;
    logic                   ring_full;
    logic                   pop;
    logic                   fire_c;
    logic                   valid_c;
    logic [1:0]             status_c;
    logic [STAMP_WIDTH-1:0] quotient;
    logic [15:0]            sat_q;
    logic                   div_done;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    assign tpm_eff    = (cfg.tpm == '0) ? 20'd1 : cfg.tpm;
    assign tpc_eff    = (cfg.tpc == '0) ? 16'd1 : cfg.tpc;
    assign period     = period_ms(cfg.rate);
    assign pre_inc    = pre_reg + 20'd1;
    assign el_inc     = elapsed_reg + 10'd1;
    assign ms_hit     = pre_inc >= tpm_eff;
    assign period_hit = el_inc >= period;
    assign ring_empty = (cnt_reg == '0);
    assign ring_full  = (cnt_reg == CNT_W'(RING_DEPTH));
    assign pop        = cmd.exec && (op == OP_READ) && !ring_empty;

    always_comb begin
        fire_c   = 1'b0;
        valid_c  = 1'b0;
        status_c = ST_OK;
        if (cmd.exec) begin
            case (op)
                OP_TICK: fire_c = running_reg && ms_hit && period_hit;
                OP_READ: begin
                    fire_c = !cfg.mode;
                    if (ring_empty) begin
                        status_c = (cfg.mode && !running_reg) ? ST_EMPTY_STOPPED
                                                               : ST_EMPTY_WAIT;
                    end else begin
                        valid_c = 1'b1;
                    end
                end
                OP_CMD: fire_c = !cfg.mode || (command_value == CMD_START);
                default: fire_c = 1'b0;
            endcase
        end
    end

    urc_div #(
        .DW(STAMP_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (ts_reg - rise_reg),
        .divisor  (tpc_eff),
        .quotient (quotient),
        .done     (div_done)
    );

    assign sat_q = (quotient > STAMP_WIDTH'(DIST_MAX)) ? DIST_MAX : quotient[15:0];

    assign stat.fall_pending = phase_reg;
    assign stat.div_done     = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg      <= '0;
            rise_reg    <= '0;
            phase_reg   <= 1'b0;
            running_reg <= 1'b0;
            pre_reg     <= '0;
            elapsed_reg <= '0;
            wr_reg      <= '0;
            rd_reg      <= '0;
            cnt_reg     <= '0;
        end else begin
            if (mode_wr) begin
                running_reg <= 1'b0;
                pre_reg     <= '0;
                elapsed_reg <= '0;
            end
            if (cmd.exec) begin
                case (op)
                    OP_TICK: begin
                        ts_reg <= ts_reg + STAMP_WIDTH'(1);
                        if (running_reg) begin
                            if (ms_hit) begin
                                pre_reg     <= '0;
                                elapsed_reg <= period_hit ? 10'd0 : el_inc;
                            end else begin
                                pre_reg <= pre_inc;
                            end
                        end
                    end
                    OP_ECHO: begin
                        rise_reg  <= ts_reg;
                        phase_reg <= 1'b1;
                    end
                    OP_READ: begin
                        if (!ring_empty) begin
                            rd_reg  <= idx_inc(rd_reg);
                            cnt_reg <= cnt_reg - CNT_W'(1);
                        end
                    end
                    OP_CMD: begin
                        if (!cfg.mode) begin
                            if (command_value != '0) begin
                                cnt_reg <= '0;
                                wr_reg  <= '0;
                                rd_reg  <= '0;
                            end
                        end else if (command_value == CMD_STOP) begin
                            running_reg <= 1'b0;
                            pre_reg     <= '0;
                            elapsed_reg <= '0;
                        end else if (command_value == CMD_START) begin
                            running_reg <= 1'b1;
                            pre_reg     <= '0;
                            elapsed_reg <= '0;
                        end
                    end
                    default: ts_reg <= ts_reg;
                endcase
            end
            if (cmd.div_start) begin
                phase_reg <= 1'b0;
            end
            // A push into a full ring drops the oldest entry by moving the read side along.
            if (cmd.push) begin
                wr_reg <= idx_inc(wr_reg);
                if (ring_full) begin
                    rd_reg <= idx_inc(rd_reg);
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            ring[wr_reg] <= sat_q;
        end
    end

    // The ring read lands directly in the output register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            fire_reg   <= fire_c;
            valid_reg  <= valid_c;
            status_reg <= status_c;
            dist_reg   <= pop ? ring[rd_reg] : 16'd0;
        end
    end

    assign fire_trigger = fire_reg;
    assign read_valid   = valid_reg;
    assign distance_cm  = dist_reg;
    assign read_status  = status_reg;

endmodule

// ----- design/urc_ctrl.sv -----
module urc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  urc_pkg::urc_op_t   op,
    output logic               m_valid,
    input  logic               m_ready,
    output urc_pkg::urc_cmd_t  cmd,
    input  urc_pkg::urc_stat_t stat
);
    import urc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } urc_state_t;

    urc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       fall;

    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign fall    = (op == OP_ECHO) && stat.fall_pending;
    assign m_valid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (fall) begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end else begin
                        cmd.exec     = 1'b1;
                        cmd.load_out = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.push     = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/ultrasonic_ranger_controller.sv -----
// Ultrasonic range-finder controller. Each input beat is a tick, an echo edge, a read
// or a command, and each produces exactly one result beat. Ticks, rising echo edges,
// reads and commands execute in the cycle they are taken, so one can be accepted every
// cycle while the result side keeps up; a beat is taken only while the output register
// is empty or its result is being taken. A falling echo edge stalls the input side while
// the restoring divider turns elapsed ticks into centimetres one quotient bit per cycle,
// and its result is loaded into the output register when the divider is done. Distances
// go into a ring of RING_DEPTH entries that drops the oldest when full. The user must
// write configuration over the APB port only while the block is idle; it does not enforce it.
module ultrasonic_ranger_controller #(
    parameter int RING_DEPTH  = urc_pkg::RING_DEPTH_DEF,
    parameter int STAMP_WIDTH = urc_pkg::STAMP_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [15:0]                s_command_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_fire_trigger,
    output logic                       m_read_valid,
    output logic [15:0]                m_distance_cm,
    output logic [1:0]                 m_read_status,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [urc_pkg::ADDR_W-1:0] paddr,
    input  logic [urc_pkg::DATA_W-1:0] pwdata,
    output logic [urc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import urc_pkg::*;

    urc_cfg_t  cfg;
    urc_cmd_t  cmd;
    urc_stat_t stat;
    logic      mode_wr;
    urc_op_t   op;

    assign op = urc_op_t'(s_op);

    urc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .mode_wr (mode_wr)
    );

    urc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    urc_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg),
        .mode_wr       (mode_wr),
        .op            (op),
        .command_value (s_command_value),
        .fire_trigger  (m_fire_trigger),
        .read_valid    (m_read_valid),
        .distance_cm   (m_distance_cm),
        .read_status   (m_read_status)
    );

    a_div_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !s_ready)
        else $error("input accepted while the divider is running");

    a_done_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> !s_ready)
        else $error("input ready on the cycle a distance is pushed");

    a_exec_push_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && cmd.push))
        else $error("ring push collides with an executed beat");

    a_valid_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_valid |-> m_read_status == ST_OK)
        else $error("valid read reported with a nonzero status");

endmodule

// ----- verif/ultrasonic_ranger_checker.sv -----
module ultrasonic_ranger_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [15:0]                s_command_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_fire_trigger,
    input  logic                       m_read_valid,
    input  logic [15:0]                m_distance_cm,
    input  logic [1:0]                 m_read_status,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [urc_pkg::ADDR_W-1:0] paddr,
    input  logic [urc_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    output int                         fail_count,
    output int                         results_due_count,
    output int                         results_checked,
    output int                         triggers_seen,
    output int                         distances_seen,
    output int                         saturated_seen
);
    import urc_pkg::*;

    localparam int RING_SLOTS = RING_DEPTH_DEF;

    typedef struct packed {
        logic        fire;
        logic        rvalid;
        logic [15:0] dist_cm;
        logic [1:0]  status;
    } ranger_result_t;

    // Shadow copy of the registers, written when an APB write is seen.
    logic        cfg_mode;
    logic [4:0]  cfg_rate;
    logic [19:0] cfg_tpm;
    logic [15:0] cfg_tpc;

    logic [31:0] stamp_now;
    logic [31:0] stamp_rise;
    logic        awaiting_fall;
    logic [15:0] distance_slots [RING_SLOTS];
    int unsigned slot_wr;
    int unsigned slot_rd;
    int unsigned slot_fill;
    logic        timer_on;
    int unsigned prescale;
    logic [9:0]  elapsed_ms;

    ranger_result_t results_due[$];

    function automatic int unsigned trigger_period_ms();
        int unsigned rate_eff;
        rate_eff = cfg_rate;
        if (rate_eff == 0) begin
            rate_eff = 1;
        end
        if (rate_eff > 16) begin
            rate_eff = 16;
        end
        return 1000 / rate_eff;
    endfunction

    function automatic ranger_result_t step_ranger(urc_op_t op, logic [15:0] cmd);
        ranger_result_t r;
        logic [31:0]    span;
        logic [31:0]    quotient;
        logic [15:0]    divisor;
        logic [15:0]    span_cm;
        int unsigned    tpm_eff;
        r = '0;
        case (op)
            OP_TICK: begin
                stamp_now = stamp_now + 32'd1;
                if (timer_on) begin
                    tpm_eff = (cfg_tpm == 0) ? 1 : cfg_tpm;
                    prescale++;
                    if (prescale >= tpm_eff) begin
                        prescale = 0;
                        elapsed_ms = elapsed_ms + 10'd1;
                        if (elapsed_ms >= trigger_period_ms()) begin
                            elapsed_ms = '0;
                            r.fire = 1'b1;
                        end
                    end
                end
            end
            OP_ECHO: begin
                if (!awaiting_fall) begin
                    stamp_rise = stamp_now;
                end else begin
                    span = stamp_now - stamp_rise;
                    divisor = (cfg_tpc == 0) ? 16'd1 : cfg_tpc;
                    quotient = span / divisor;
                    span_cm = (quotient > DIST_MAX) ? DIST_MAX : quotient[15:0];
                    // A full ring drops its oldest distance.
                    distance_slots[slot_wr] = span_cm;
                    slot_wr = (slot_wr + 1) % RING_SLOTS;
                    if (slot_fill >= RING_SLOTS) begin
                        slot_rd = (slot_rd + 1) % RING_SLOTS;
                    end else begin
                        slot_fill++;
                    end
                end
                awaiting_fall = !awaiting_fall;
            end
            OP_READ: begin
                if (!cfg_mode) begin
                    r.fire = 1'b1;
                end
                if (slot_fill == 0) begin
                    r.status = (cfg_mode && !timer_on) ? ST_EMPTY_STOPPED : ST_EMPTY_WAIT;
                end else begin
                    r.dist_cm = distance_slots[slot_rd];
                    r.rvalid = 1'b1;
                    slot_rd = (slot_rd + 1) % RING_SLOTS;
                    slot_fill--;
                end
            end
            OP_CMD: begin
                if (!cfg_mode) begin
                    if (cmd != 16'd0) begin
                        slot_fill = 0;
                        slot_wr = 0;
                        slot_rd = 0;
                    end
                    r.fire = 1'b1;
                end else if (cmd == CMD_STOP) begin
                    timer_on = 1'b0;
                    prescale = 0;
                    elapsed_ms = '0;
                end else if (cmd == CMD_START) begin
                    timer_on = 1'b1;
                    prescale = 0;
                    elapsed_ms = '0;
                    r.fire = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch_beats
        ranger_result_t want;
        if (!aresetn) begin
            cfg_mode = MODE_RESET;
            cfg_rate = RATE_RESET;
            cfg_tpm = TPM_RESET;
            cfg_tpc = TPC_RESET;
            stamp_now = '0;
            stamp_rise = '0;
            awaiting_fall = 1'b0;
            slot_wr = 0;
            slot_rd = 0;
            slot_fill = 0;
            timer_on = 1'b0;
            prescale = 0;
            elapsed_ms = '0;
            results_due.delete();
            fail_count = 0;
            results_due_count = 0;
            results_checked = 0;
            triggers_seen = 0;
            distances_seen = 0;
            saturated_seen = 0;
        end else begin
            // Results are matched before this edge's input beat is predicted.
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with no outstanding input beat");
                end else begin
                    want = results_due.pop_front();
                    if (m_fire_trigger !== want.fire) begin
                        report_mismatch($sformatf("result %0d: fire_trigger expected %0d, got %0d",
                            results_checked, want.fire, m_fire_trigger));
                    end
                    if (m_read_valid !== want.rvalid) begin
                        report_mismatch($sformatf("result %0d: read_valid expected %0d, got %0d",
                            results_checked, want.rvalid, m_read_valid));
                    end
                    if (m_distance_cm !== want.dist_cm) begin
                        report_mismatch($sformatf("result %0d: distance_cm expected %0d, got %0d",
                            results_checked, want.dist_cm, m_distance_cm));
                    end
                    if (m_read_status !== want.status) begin
                        report_mismatch($sformatf("result %0d: read_status expected %0d, got %0d",
                            results_checked, want.status, m_read_status));
                    end
                    results_checked++;
                    if (want.fire) begin
                        triggers_seen++;
                    end
                    if (want.rvalid) begin
                        distances_seen++;
                        if (want.dist_cm == DIST_MAX) begin
                            saturated_seen++;
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (urc_reg_t'(paddr[ADDR_W-1:2]))
                    REG_MODE: begin
                        cfg_mode = pwdata[0];
                        timer_on = 1'b0;
                        prescale = 0;
                        elapsed_ms = '0;
                    end
                    REG_RATE: cfg_rate = pwdata[4:0];
                    REG_TPM:  cfg_tpm = pwdata[19:0];
                    REG_TPC:  cfg_tpc = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                results_due.push_back(step_ranger(urc_op_t'(s_op), s_command_value));
            end
            results_due_count = results_due.size();
        end
    end

endmodule

// ----- verif/ultrasonic_ranger_controller_test.sv -----
module ultrasonic_ranger_controller_test;
    import urc_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = STAMP_WIDTH_DEF + 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int RANDOM_PHASES   = 9;
    localparam int ECHO_TICKS      = 40;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_op;
    logic [15:0]       s_command_value;
    logic              m_valid;
    logic              m_ready;
    logic              m_fire_trigger;
    logic              m_read_valid;
    logic [15:0]       m_distance_cm;
    logic [1:0]        m_read_status;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int results_due_count;
    int results_checked;
    int triggers_seen;
    int distances_seen;
    int saturated_seen;

    int send_idle_pct;
    int stall_pct;
    int cycle_count;

    ultrasonic_ranger_controller dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_command_value (s_command_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fire_trigger  (m_fire_trigger),
        .m_read_valid    (m_read_valid),
        .m_distance_cm   (m_distance_cm),
        .m_read_status   (m_read_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ultrasonic_ranger_checker ranger_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_command_value   (s_command_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fire_trigger    (m_fire_trigger),
        .m_read_valid      (m_read_valid),
        .m_distance_cm     (m_distance_cm),
        .m_read_status     (m_read_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .fail_count        (fail_count),
        .results_due_count (results_due_count),
        .results_checked   (results_checked),
        .triggers_seen     (triggers_seen),
        .distances_seen    (distances_seen),
        .saturated_seen    (saturated_seen)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                cycle_count, results_due_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(urc_op_t op, logic [15:0] cmd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_command_value <= cmd;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_due_count != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(urc_reg_t r, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic mode, logic [4:0] rate, logic [19:0] tpm, logic [15:0] tpc);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_MODE, DATA_W'(mode));
        write_reg(REG_RATE, DATA_W'(rate));
        write_reg(REG_TPM, DATA_W'(tpm));
        write_reg(REG_TPC, DATA_W'(tpc));
    endtask

    function automatic logic [15:0] random_command();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return CMD_START;
        end else if (pick < 7) begin
            return CMD_STOP;
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Mostly whole measurements, tick runs, reads and commands; a few stray beats
    // break the rise/fall pairing on purpose.
    task automatic run_traffic(int items);
        int left;
        int kind;
        int n;
        left = items;
        while (left > 0) begin
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
                send_beat(OP_ECHO, 16'($urandom));
                repeat (n) send_beat(OP_TICK, 16'($urandom));
                send_beat(OP_ECHO, 16'($urandom));
                left -= n + 2;
            end else if (kind < 55) begin
                n = $urandom_range(1, 120);
                repeat (n) send_beat(OP_TICK, 16'($urandom));
                left -= n;
            end else if (kind < 75) begin
                n = $urandom_range(1, 3);
                repeat (n) send_beat(OP_READ, 16'($urandom));
                left -= n;
            end else if (kind < 90) begin
                send_beat(OP_CMD, random_command());
                left--;
            end else begin
                send_beat(urc_op_t'($urandom_range(0, 3)), 16'($urandom));
                left--;
            end
        end
    endtask

    task automatic random_phase(int p);
        case (p)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
                configure(1'b0, 5'd16, 20'd1, 16'd1);
            end
            1: begin
                send_idle_pct = 71;
                stall_pct = 0;
                configure(1'b1, 5'd16, 20'd1, 16'd3);
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 71;
                configure(1'b1, 5'd31, 20'd2, 16'd1);
            end
            3: begin
                send_idle_pct = 33;
                stall_pct = 33;
                configure(1'b0, 5'd7, 20'd1000000, 16'hFFFF);
            end
            4: begin
                send_idle_pct = 33;
                stall_pct = 33;
                configure(1'b1, 5'd1, 20'd1, 16'd2);
            end
            5: begin
                send_idle_pct = 0;
                stall_pct = 0;
                configure(1'b1, 5'($urandom_range(0, 31)), 20'($urandom_range(1, 3)),
                    16'($urandom_range(1, 8)));
            end
            6: begin
                send_idle_pct = 71;
                stall_pct = 0;
                configure(1'b0, 5'($urandom_range(0, 31)), 20'($urandom),
                    16'($urandom));
            end
            7: begin
                send_idle_pct = 0;
                stall_pct = 71;
                configure(1'b1, 5'd16, 20'hFFFFF, 16'($urandom_range(1, 4)));
            end
            default: begin
                send_idle_pct = 33;
                stall_pct = 33;
                configure(1'b1, 5'($urandom_range(8, 31)), 20'd1,
                    16'($urandom_range(1, 16)));
            end
        endcase
        run_traffic(ITEMS_PER_PHASE);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_TICK;
        s_command_value = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // One-shot mode with reset registers: empty read, plain command, a short
        // echo that rounds to zero, and a clearing command.
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, CMD_STOP);
        send_beat(OP_ECHO, 16'd0);
        repeat (3) send_beat(OP_TICK, 16'hFFFF);
        send_beat(OP_ECHO, 16'd0);
        drain_results();
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, 16'hFFFF);

        // Continuous mode with zero divisors and a zero rate.
        configure(1'b1, 5'd0, 20'd0, 16'd0);
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, CMD_START);
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, 16'd2);
        send_beat(OP_ECHO, 16'd0);
        repeat (2) send_beat(OP_TICK, 16'd0);
        send_beat(OP_ECHO, 16'd0);
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, CMD_STOP);
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, 16'h8000);

        // A measured echo with the periodic trigger running at a rate above
        // the maximum.
        configure(1'b1, 5'd31, 20'd1, 16'd1);
        send_beat(OP_CMD, CMD_START);
        send_beat(OP_ECHO, 16'd0);
        repeat (ECHO_TICKS) send_beat(OP_TICK, 16'd0);
        send_beat(OP_ECHO, 16'd0);
        send_beat(OP_READ, 16'd0);
        send_beat(OP_CMD, CMD_STOP);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_phase(p);
        end

        stall_pct = 0;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Checked %0d result beats over %0d traffic phases in one-shot and continuous modes.",
            results_checked, RANDOM_PHASES);
        $display("Seen %0d triggers and %0d popped distances, %0d of them saturated.",
            triggers_seen, distances_seen, saturated_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
